>>> rtl/hsvrh_pkg.sv
// Package for the HSV region histogram: sizes, request types and bin selection.
package hsvrh_pkg;

  localparam int NUM_HUE_BINS      = 8;
  localparam int NUM_SAT_BINS      = 4;
  localparam int NUM_VAL_BINS      = 4;
  localparam int MAX_REGION_PIXELS = 65536;

  localparam int HUE_SPAN   = 180;
  localparam int NUM_COLOR  = NUM_HUE_BINS * NUM_SAT_BINS;
  localparam int TOTAL_BINS = NUM_COLOR + NUM_VAL_BINS;
  localparam int BIN_W      = $clog2(TOTAL_BINS);
  localparam int HUE_W      = $clog2(NUM_HUE_BINS);
  localparam int SAT_W      = $clog2(NUM_SAT_BINS);
  localparam int VAL_W      = $clog2(NUM_VAL_BINS);
  localparam int CNT_W      = $clog2(MAX_REGION_PIXELS + 1);
  localparam int FRAC_W     = 17;
  localparam int FRAC_ONE   = 65536;
  localparam int ITER_W     = $clog2(FRAC_W);
  localparam int PIX_W      = 8;
  localparam int BIN_IDX_W  = 6;
  localparam int HPROD_W    = PIX_W + HUE_W + 1;
  localparam int SPROD_W    = PIX_W + 4;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REGION_PIXELS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(TOTAL_BINS - 1);

  localparam logic [7:0] SAT_TH_RESET = 8'd15;
  localparam logic [7:0] VAL_TH_RESET = 8'd30;

  typedef enum logic [0:0] {
    REG_SAT_TH = 1'b0,
    REG_VAL_TH = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_PIXEL,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] bin;
  } bin_req_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] area;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
  endfunction

  function automatic logic [BIN_W-1:0] pick_bin(input logic [PIX_W-1:0] h,
                                                input logic [PIX_W-1:0] s,
                                                input logic [PIX_W-1:0] v,
                                                input logic [7:0]       sat_th,
                                                input logic [7:0]       val_th);
    logic [HPROD_W-1:0] hprod;
    logic [SPROD_W-1:0] sprod;
    logic [SPROD_W-1:0] vprod;
    logic [HUE_W-1:0]   hi;
    logic [SAT_W-1:0]   si;
    logic [VAL_W-1:0]   vi;
    hprod = HPROD_W'(h) * HPROD_W'(NUM_HUE_BINS);
    sprod = SPROD_W'(s) * SPROD_W'(NUM_SAT_BINS);
    vprod = SPROD_W'(v) * SPROD_W'(NUM_VAL_BINS);
    si    = sprod[PIX_W +: SAT_W];
    vi    = vprod[PIX_W +: VAL_W];
    hi    = '0;
    for (int k = 1; k < NUM_HUE_BINS; k++) begin
      if (hprod >= HPROD_W'(k * HUE_SPAN)) begin
        hi = HUE_W'(k);
      end
    end
    if (s < sat_th || v < val_th) begin
      return BIN_W'(NUM_COLOR) + BIN_W'(vi);
    end
    return BIN_W'(hi) * BIN_W'(NUM_SAT_BINS) + BIN_W'(si);
  endfunction

endpackage

>>> rtl/hsvrh_bin_mem.sv
// Bin count memory with read-modify-write increment, forwarding and clear.
module hsvrh_bin_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hsvrh_pkg::bin_req_t         inc_i,
  input  hsvrh_pkg::bin_req_t         rd_i,
  input  logic                        clear_i,
  output logic [hsvrh_pkg::CNT_W-1:0] count_o
);

  logic [hsvrh_pkg::CNT_W-1:0] mem [hsvrh_pkg::TOTAL_BINS];
  logic [hsvrh_pkg::TOTAL_BINS-1:0] vld_q;

  logic [hsvrh_pkg::BIN_W-1:0] raddr;
  logic [hsvrh_pkg::BIN_W-1:0] raddr_q;
  logic [hsvrh_pkg::CNT_W-1:0] rd_data_q;
  logic                        rd_vld_q;
  logic                        upd_valid_q;
  logic [hsvrh_pkg::CNT_W-1:0] cur;
  logic [hsvrh_pkg::CNT_W-1:0] upd_count;
  logic                        fwd_valid_q;
  logic [hsvrh_pkg::BIN_W-1:0] fwd_bin_q;
  logic [hsvrh_pkg::CNT_W-1:0] fwd_data_q;

  assign raddr = inc_i.valid ? inc_i.bin : rd_i.bin;

  always_comb begin
    if (fwd_valid_q && fwd_bin_q == raddr_q) begin
      cur = fwd_data_q;
    end else if (rd_vld_q) begin
      cur = rd_data_q;
    end else begin
      cur = '0;
    end
  end

  assign upd_count = hsvrh_pkg::sat_inc(cur);
  assign count_o   = cur;

  always_ff @(posedge clk_i) begin
    if (upd_valid_q) begin
      mem[raddr_q] <= upd_count;
    end
    rd_data_q  <= mem[raddr];
    raddr_q    <= raddr;
    fwd_bin_q  <= raddr_q;
    fwd_data_q <= upd_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      upd_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      rd_vld_q    <= vld_q[raddr];
      upd_valid_q <= inc_i.valid;
      fwd_valid_q <= upd_valid_q;
      if (clear_i) begin
        vld_q <= '0;
      end else if (upd_valid_q) begin
        vld_q[raddr_q] <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/hsvrh_div.sv
// Radix-2 restoring divider producing count*65536/area, one quotient bit per cycle.
module hsvrh_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsvrh_pkg::div_req_t req_i,
  output hsvrh_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [hsvrh_pkg::ITER_W-1:0] iter_q, iter_d;
  logic [hsvrh_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [hsvrh_pkg::CNT_W-1:0]  dvs_q, dvs_d;
  logic [hsvrh_pkg::FRAC_W-1:0] sh_q, sh_d;
  logic [hsvrh_pkg::FRAC_W-1:0] quo_q, quo_d;
  logic [hsvrh_pkg::CNT_W:0]    trial;
  logic                         qbit;

  assign trial = {rem_q, sh_q[hsvrh_pkg::FRAC_W-1]};
  assign qbit  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      iter_d = hsvrh_pkg::ITER_W'(hsvrh_pkg::FRAC_W - 1);
      rem_d  = req_i.count >> 1;
      dvs_d  = req_i.area;
      sh_d   = {req_i.count[0], {(hsvrh_pkg::FRAC_W-1){1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? hsvrh_pkg::CNT_W'(trial - {1'b0, dvs_q})
                   : trial[hsvrh_pkg::CNT_W-1:0];
      quo_d = {quo_q[hsvrh_pkg::FRAC_W-2:0], qbit};
      sh_d  = sh_q << 1;
      if (iter_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        iter_d = iter_q - hsvrh_pkg::ITER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    sh_q   <= sh_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> rtl/hsv_region_histogram.sv
// Top level of the HSV region histogram: register port, drain sequencer, output register.
//
// Pixels are taken one per cycle outside a drain; the bin counts live in a 36-entry memory
// that is read, incremented and written back, with forwarding covering back-to-back hits
// on one bin. On the pixel marked last, input stalls while all 36 bins are drained: each
// bin passes a memory read state, a load state and the bit-serial divider (17 quotient
// bits and a done strobe), and the output side may stall the drain further. The counts
// are cleared in the cycle the final bin enters the output register, and the next region
// may start in the following cycle.
module hsv_region_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  bin_index_o,
  output logic [16:0] bin_fraction_o,
  output logic        last_bin_o
);

  logic [7:0] sat_th_q;
  logic [7:0] val_th_q;
  hsvrh_pkg::reg_idx_e reg_idx;

  hsvrh_pkg::state_e state_q, state_d;
  logic [hsvrh_pkg::BIN_W-1:0] k_q, k_d;
  logic [hsvrh_pkg::CNT_W-1:0] pix_q, pix_d;
  logic                        in_acc;
  logic                        load;
  logic                        clear;

  hsvrh_pkg::bin_req_t inc_req;
  hsvrh_pkg::bin_req_t rd_req;
  hsvrh_pkg::div_req_t div_req;
  hsvrh_pkg::div_rsp_t div_rsp;
  logic [hsvrh_pkg::CNT_W-1:0] bin_count;

  logic                            out_valid_q, out_valid_d;
  logic [hsvrh_pkg::BIN_IDX_W-1:0] out_bin_q;
  logic [hsvrh_pkg::FRAC_W-1:0]    out_frac_q;
  logic                            out_last_q;

  assign reg_idx = hsvrh_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      hsvrh_pkg::REG_SAT_TH: prdata = {24'b0, sat_th_q};
      hsvrh_pkg::REG_VAL_TH: prdata = {24'b0, val_th_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_th_q <= hsvrh_pkg::SAT_TH_RESET;
      val_th_q <= hsvrh_pkg::VAL_TH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        hsvrh_pkg::REG_SAT_TH: sat_th_q <= pwdata[7:0];
        hsvrh_pkg::REG_VAL_TH: val_th_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != hsvrh_pkg::ST_PIXEL);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign inc_req.valid = in_acc;
  assign inc_req.bin   = hsvrh_pkg::pick_bin(hue_i, saturation_i, brightness_i,
                                             sat_th_q, val_th_q);

  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    rd_req.valid  = 1'b0;
    rd_req.bin    = k_q;
    div_req.start = 1'b0;
    div_req.count = bin_count;
    div_req.area  = pix_q;
    load          = 1'b0;
    clear         = 1'b0;
    case (state_q)
      hsvrh_pkg::ST_PIXEL: begin
        if (in_acc && last_pixel_i) begin
          k_d     = '0;
          state_d = hsvrh_pkg::ST_READ;
        end
      end
      hsvrh_pkg::ST_READ: begin
        rd_req.valid = 1'b1;
        state_d      = hsvrh_pkg::ST_LOAD;
      end
      hsvrh_pkg::ST_LOAD: begin
        div_req.start = 1'b1;
        state_d       = hsvrh_pkg::ST_DIV;
      end
      hsvrh_pkg::ST_DIV, hsvrh_pkg::ST_EMIT: begin
        if (div_rsp.done || state_q == hsvrh_pkg::ST_EMIT) begin
          if (!out_valid_q || !out_stall_i) begin
            load = 1'b1;
            if (k_q == hsvrh_pkg::LAST_BIN) begin
              clear   = 1'b1;
              state_d = hsvrh_pkg::ST_PIXEL;
            end else begin
              k_d     = k_q + hsvrh_pkg::BIN_W'(1);
              state_d = hsvrh_pkg::ST_READ;
            end
          end else begin
            state_d = hsvrh_pkg::ST_EMIT;
          end
        end
      end
      default: state_d = hsvrh_pkg::ST_PIXEL;
    endcase
  end

  always_comb begin
    pix_d = pix_q;
    if (clear) begin
      pix_d = '0;
    end else if (in_acc) begin
      pix_d = hsvrh_pkg::sat_inc(pix_q);
    end
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsvrh_pkg::ST_PIXEL;
      k_q         <= '0;
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pix_q       <= pix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_bin_q  <= hsvrh_pkg::BIN_IDX_W'(k_q);
      out_frac_q <= div_rsp.quotient;
      out_last_q <= (k_q == hsvrh_pkg::LAST_BIN);
    end
  end

  hsvrh_bin_mem u_bin_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inc_i   (inc_req),
    .rd_i    (rd_req),
    .clear_i (clear),
    .count_o (bin_count)
  );

  hsvrh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign bin_index_o    = out_bin_q;
  assign bin_fraction_o = out_frac_q;
  assign last_bin_o     = out_last_q;

  a_last_bin_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_bin_o) |-> (bin_index_o == 6'(hsvrh_pkg::TOTAL_BINS - 1)))
    else $error("last bin flag on wrong bin index");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bin_fraction_o <= 17'(hsvrh_pkg::FRAC_ONE)))
    else $error("bin fraction above one");

  a_drain_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_pixel_i) |=> in_stall_o)
    else $error("input not stalled after last pixel");

  a_area_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (pix_q != '0))
    else $error("drain started with zero pixel count");

endmodule

>>> tb/hsv_region_histogram_test.sv
// Self-checking testbench for the HSV region histogram: pixel driver, bin monitor, predictor.
module hsv_region_histogram_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [5:0]  index;
    logic [16:0] fraction;
    logic        last;
  } bin_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  hue_i = '0;
  logic [7:0]  saturation_i = '0;
  logic [7:0]  brightness_i = '0;
  logic        last_pixel_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  bin_index_o;
  logic [16:0] bin_fraction_o;
  logic        last_bin_o;

  hsv_region_histogram u_top (.*);

  always #5 clk_i = ~clk_i;

  logic [7:0]                  sat_th_q = hsvrh_pkg::SAT_TH_RESET;
  logic [7:0]                  val_th_q = hsvrh_pkg::VAL_TH_RESET;
  logic [hsvrh_pkg::CNT_W-1:0] bin_tally [hsvrh_pkg::TOTAL_BINS];
  logic [hsvrh_pkg::CNT_W-1:0] area_tally;

  pixel_t      pixel_q[$];
  bin_result_t due_bins[$];
  pixel_t      next_px;
  bin_result_t got_due;

  int mismatches = 0;
  int regions = 0;
  int pixels = 0;
  int bins_checked = 0;
  int settings = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit in_taken = 1'b0;
  bit hold_done = 1'b0;
  bit long_hold_arm = 1'b0;
  stall_mode_e stall_mode = STALL_NONE;

  function automatic int unsigned bin_for(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    int unsigned hue_slot;
    if (s < sat_th_q || v < val_th_q) begin
      return hsvrh_pkg::NUM_COLOR + ((int'(v) * hsvrh_pkg::NUM_VAL_BINS) >> 8);
    end
    hue_slot = (int'(h) * hsvrh_pkg::NUM_HUE_BINS) / hsvrh_pkg::HUE_SPAN;
    if (hue_slot >= hsvrh_pkg::NUM_HUE_BINS) begin
      hue_slot = hsvrh_pkg::NUM_HUE_BINS - 1;
    end
    return hue_slot * hsvrh_pkg::NUM_SAT_BINS + ((int'(s) * hsvrh_pkg::NUM_SAT_BINS) >> 8);
  endfunction

  function automatic void count_pixel(pixel_t p);
    int unsigned b;
    bin_result_t r;
    b = bin_for(p.hue, p.sat, p.val);
    if (bin_tally[b] != hsvrh_pkg::CNT_MAX) begin
      bin_tally[b] = bin_tally[b] + 1'b1;
    end
    if (area_tally != hsvrh_pkg::CNT_MAX) begin
      area_tally = area_tally + 1'b1;
    end
    pixels++;
    if (p.last) begin
      regions++;
      for (int k = 0; k < hsvrh_pkg::TOTAL_BINS; k++) begin
        r.index    = 6'(k);
        r.fraction = 17'((longint'(bin_tally[k]) << 16) / longint'(area_tally));
        r.last     = (k == hsvrh_pkg::TOTAL_BINS - 1);
        due_bins.push_back(r);
        bin_tally[k] = '0;
      end
      area_tally = '0;
    end
  endfunction

  function automatic logic [7:0] near_or_any(logic [7:0] th);
    if ($urandom_range(0, 3) == 0) begin
      return 8'(int'(th) + int'($urandom_range(0, 2)) - 1);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic last);
    pixel_t p;
    p = '{h, s, v, last};
    pixel_q.push_back(p);
  endfunction

  function automatic void queue_region(int n);
    logic [7:0] h;
    for (int i = 0; i < n; i++) begin
      h = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(180, 255))
                                      : 8'($urandom_range(0, 179));
      queue_pixel(h, near_or_any(sat_th_q), near_or_any(val_th_q), i == n - 1);
    end
  endfunction

  task automatic set_threshold(hsvrh_pkg::reg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(int'(idx) * 4);
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== value) begin
      $error("register %s expected %0d actual %0d", idx.name(), value, prdata[7:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == hsvrh_pkg::REG_SAT_TH) begin
      sat_th_q = value;
    end else begin
      val_th_q = value;
    end
    settings++;
  endtask

  task automatic settle();
    wait (pixel_q.size() == 0 && !in_valid_i);
    wait (due_bins.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // pixel driver: bursts and gaps, hold while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        next_px = pixel_q.pop_front();
        in_valid_i   <= 1'b1;
        hue_i        <= next_px.hue;
        saturation_i <= next_px.sat;
        brightness_i <= next_px.val;
        last_pixel_i <= next_px.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall pattern plus one long hold-off
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (!hold_done && long_hold_arm && out_valid_o) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        default:     out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      count_pixel('{hue_i, saturation_i, brightness_i, last_pixel_i});
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_bins.size() == 0) begin
        $error("unexpected bin_index %0d bin_fraction %0d", bin_index_o, bin_fraction_o);
        mismatches++;
      end else begin
        got_due = due_bins.pop_front();
        bins_checked++;
        if (bin_index_o !== got_due.index) begin
          $error("bin_index expected %0d actual %0d", got_due.index, bin_index_o);
          mismatches++;
        end
        if (bin_fraction_o !== got_due.fraction) begin
          $error("bin_fraction expected %0d actual %0d", got_due.fraction, bin_fraction_o);
          mismatches++;
        end
        if (last_bin_o !== got_due.last) begin
          $error("last_bin expected %0d actual %0d", got_due.last, last_bin_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int filled;
    int n;
    logic [7:0] s_set;
    logic [7:0] v_set;
    for (int k = 0; k < hsvrh_pkg::TOTAL_BINS; k++) begin
      bin_tally[k] = '0;
    end
    area_tally = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    queue_pixel(8'd179, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd180, 8'd128, 8'd200, 1'b0);
    queue_pixel(8'd255, 8'd64,  8'd64,  1'b0);
    queue_pixel(8'd22,  8'd14,  8'd255, 1'b0);
    queue_pixel(8'd22,  8'd15,  8'd255, 1'b0);
    queue_pixel(8'd23,  8'd15,  8'd29,  1'b0);
    queue_pixel(8'd23,  8'd15,  8'd30,  1'b0);
    queue_pixel(8'd90,  8'd0,   8'd0,   1'b0);
    queue_pixel(8'd170, 8'd127, 8'd191, 1'b0);
    queue_pixel(8'd45,  8'd200, 8'd100, 1'b1);
    queue_pixel(8'd100, 8'd255, 8'd255, 1'b1);
    queue_pixel(8'hAA,  8'h55,  8'hAA,  1'b0);
    queue_pixel(8'h55,  8'hAA,  8'h55,  1'b1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin s_set = 8'd0;   v_set = 8'd0;   end
        1: begin s_set = 8'd255; v_set = 8'd255; end
        2: begin s_set = 8'd0;   v_set = 8'd255; end
        3: begin s_set = 8'd255; v_set = 8'd0;   end
        default: begin
          s_set = 8'($urandom_range(0, 80));
          v_set = 8'($urandom_range(0, 80));
        end
      endcase
      set_threshold(hsvrh_pkg::REG_SAT_TH, s_set);
      set_threshold(hsvrh_pkg::REG_VAL_TH, v_set);
      if (phase == 0) begin
        long_hold_arm = 1'b1;
      end
      filled = 0;
      while (filled < 26) begin
        n = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
        queue_region(n);
        filled += n;
      end
      settle();
    end

    $display("Run covered %0d regions, %0d pixels, %0d bin results, %0d register writes.",
             regions, pixels, bins_checked, settings);
    if (mismatches == 0 && due_bins.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
